// File: src/gga_pkg.sv
// Shared types, constants and bit-order helpers for the GHASH accumulator.
package gga_pkg;

    localparam int BLK_W     = 128;
    localparam int HALF_W    = 64;
    localparam int VB_W      = 5;
    localparam int NUM_BYTES = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HI = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LO = 1'b1;

    typedef logic [BLK_W-1:0] t_u128;

    // Registered text block as it leaves the input stage.
    typedef struct packed {
        t_u128 data;
        logic  upd;
        logic  last;
    } t_blk;

    // GCM numbers bit 0 as the top bit; polynomial math wants it as bit 0.
    function automatic t_u128 rev128(input t_u128 v);
        t_u128 r;
        for (int i = 0; i < BLK_W; i++) begin
            r[i] = v[BLK_W-1-i];
        end
        return r;
    endfunction

endpackage

// File: src/gga_if.sv
// Valid/ready channel interfaces for text blocks and tags.
interface gga_in_if
    import gga_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] data_hi;
    logic [HALF_W-1:0] data_lo;
    logic [VB_W-1:0]   valid_bytes;
    logic              last;

    modport source (output valid, data_hi, data_lo, valid_bytes, last, input ready);
    modport sink   (input valid, data_hi, data_lo, valid_bytes, last, output ready);
endinterface

interface gga_out_if
    import gga_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] tag_hi;
    logic [HALF_W-1:0] tag_lo;

    modport source (output valid, tag_hi, tag_lo, input ready);
    modport sink   (input valid, tag_hi, tag_lo, output ready);
endinterface

// File: src/ghash_gf128_accumulator.sv
// Data path: a last block accepted at the input passes through the input register and is then
// loaded into the tag register, which presents the tag.
// Throughput: one block per cycle; the combinational multiply closes the accumulator loop.
// A last block stalls only while the previous tag is still waiting at the output.
// Reset clears the key, the accumulator and both stage valid flags.
// Top level of the GHASH accumulator: key registers, accumulator and tag register.
module ghash_gf128_accumulator
    import gga_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [HALF_W-1:0]    i_cfg_data,
    gga_in_if.sink               i_blk,
    gga_out_if.source            o_tag
);

    logic [HALF_W-1:0] r_key_hi;
    logic [HALF_W-1:0] r_key_lo;
    t_u128             r_acc;
    t_u128             n_acc;
    t_u128             r_tag;
    logic              r_out_valid;

    logic  w_s1_valid;
    t_blk  w_s1;
    logic  w_adv;
    t_u128 w_prod;
    t_u128 w_acc_upd;

    gga_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_blk   (i_blk),
        .i_take  (w_adv),
        .o_valid (w_s1_valid),
        .o_blk   (w_s1)
    );

    gga_gfmul u_mul (
        .i_a (r_acc ^ w_s1.data),
        .i_b ({r_key_hi, r_key_lo}),
        .o_p (w_prod)
    );

    // A last block needs a free tag register; other blocks always move on.
    assign w_adv     = w_s1_valid && (!w_s1.last || !r_out_valid || o_tag.ready);
    assign w_acc_upd = w_s1.upd ? w_prod : r_acc;
    assign n_acc     = w_s1.last ? '0 : w_acc_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi    <= '0;
            r_key_lo    <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_KEY_HI: r_key_hi <= i_cfg_data;
                    REG_KEY_LO: r_key_lo <= i_cfg_data;
                    default:    r_key_hi <= r_key_hi;
                endcase
            end
            if (w_adv) begin
                r_acc <= n_acc;
            end
            if (w_adv && w_s1.last) begin
                r_out_valid <= 1'b1;
            end else if (o_tag.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_adv && w_s1.last) begin
            r_tag <= w_acc_upd;
        end
    end

    assign o_tag.valid  = r_out_valid;
    assign o_tag.tag_hi = r_tag[BLK_W-1:HALF_W];
    assign o_tag.tag_lo = r_tag[HALF_W-1:0];

`ifndef SYNTHESIS
    a_clear_after_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_s1.last) |=> (r_acc == '0 && r_out_valid))
        else $error("accumulator not cleared or tag not loaded after last block");

    a_acc_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_acc))
        else $error("accumulator changed without a block transaction");

    a_acc_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !w_s1.upd && !w_s1.last) |=> $stable(r_acc))
        else $error("empty block changed the accumulator");

    a_no_tag_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_tag.ready) |-> !(w_adv && w_s1.last))
        else $error("pending tag overwritten");
`endif

endmodule

// File: src/gga_in_stage.sv
// Input register: masks padding bytes and holds one text block transaction.
module gga_in_stage
    import gga_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    gga_in_if.sink      i_blk,
    input  logic        i_take,
    output logic        o_valid,
    output t_blk        o_blk
);

    logic  r_valid;
    t_blk  r_blk;
    t_blk  n_blk;
    t_u128 w_raw;
    logic  w_acc;

    assign w_raw       = {i_blk.data_hi, i_blk.data_lo};
    assign i_blk.ready = !r_valid || i_take;
    assign w_acc       = i_blk.valid && i_blk.ready;

    // Byte k is kept when it lies below the valid count; counts above 16 keep all.
    always_comb begin
        for (int k = 0; k < NUM_BYTES; k++) begin
            n_blk.data[BLK_W-1-8*k -: 8] =
                (i_blk.valid_bytes > VB_W'(k)) ? w_raw[BLK_W-1-8*k -: 8] : 8'h00;
        end
        n_blk.upd  = (i_blk.valid_bytes != '0);
        n_blk.last = i_blk.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_acc) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
        if (w_acc) begin
            r_blk <= n_blk;
        end
    end

    assign o_valid = r_valid;
    assign o_blk   = r_blk;

endmodule

// File: src/gga_gfmul.sv
// Combinational GF(2^128) multiplier in GCM bit order.
module gga_gfmul
    import gga_pkg::*;
(
    input  t_u128 i_a,
    input  t_u128 i_b,
    output t_u128 o_p
);

    t_u128              w_a;
    t_u128              w_b;
    logic [2*BLK_W-2:0] w_prod;
    logic [BLK_W+6:0]   w_fold1;
    logic [6:0]         w_over;
    t_u128              w_over_ext;
    t_u128              w_red;

    assign w_a = rev128(i_a);
    assign w_b = rev128(i_b);

    // Each product bit is the parity of its own diagonal of partial terms.
    always_comb begin
        for (int j = 0; j < 2*BLK_W-1; j++) begin
            w_prod[j] = 1'b0;
            for (int i = 0; i < BLK_W; i++) begin
                if (i <= j && j - i < BLK_W) begin
                    w_prod[j] = w_prod[j] ^ (w_a[i] & w_b[j-i]);
                end
            end
        end
    end

    // x^128 = x^7 + x^2 + x + 1; the first fold spills at most into bit 133.
    always_comb begin
        logic [BLK_W+6:0] h;
        h       = {8'b0, w_prod[2*BLK_W-2:BLK_W]};
        w_fold1 = {7'b0, w_prod[BLK_W-1:0]} ^ h ^ (h << 1) ^ (h << 2) ^ (h << 7);
    end

    assign w_over     = w_fold1[BLK_W+6:BLK_W];
    assign w_over_ext = {{(BLK_W-7){1'b0}}, w_over};
    assign w_red      = w_fold1[BLK_W-1:0] ^ w_over_ext ^ (w_over_ext << 1)
                      ^ (w_over_ext << 2) ^ (w_over_ext << 7);
    assign o_p        = rev128(w_red);

endmodule

// File: dv/ghash_gf128_accumulator_test.sv
// Self-checking testbench for the GHASH accumulator: predicted tags against the block's tags.
module ghash_gf128_accumulator_test;
    import gga_pkg::*;

    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [HALF_W-1:0]    i_cfg_data;

    gga_in_if  blk_if ();
    gga_out_if tag_if ();

    ghash_gf128_accumulator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_blk      (blk_if),
        .o_tag      (tag_if)
    );

    // Predicted state of the block.
    t_u128 hash_key;
    t_u128 ghash_acc;
    t_u128 tag_q[$];

    int  errors;
    int  blocks_sent;
    int  quiet_cycles;
    bit  src_idle_on;
    bit  sink_idle_on;
    bit  hold_req;

    always #6 i_clk = ~i_clk;

    // Carry-less multiply in GCM bit order: bit 127 of the vector is bit 0 of the block.
    function automatic t_u128 gf128_mul(input t_u128 x, input t_u128 y);
        t_u128 z;
        t_u128 v;
        logic  lsb;
        z = '0;
        v = y;
        for (int i = 0; i < BLK_W; i++) begin
            if (x[BLK_W-1-i]) begin
                z ^= v;
            end
            lsb = v[0];
            v = v >> 1;
            if (lsb) begin
                v[127:120] ^= 8'hE1;
            end
        end
        return z;
    endfunction

    function automatic void ghash_absorb(input t_u128 blk, input logic [VB_W-1:0] vb,
                                         input logic lst);
        int    nb;
        t_u128 mask;
        nb = (int'(vb) > NUM_BYTES) ? NUM_BYTES : int'(vb);
        if (nb != 0) begin
            mask = {BLK_W{1'b1}} << (8 * (NUM_BYTES - nb));
            ghash_acc = gf128_mul(ghash_acc ^ (blk & mask), hash_key);
        end
        if (lst) begin
            tag_q.push_back(ghash_acc);
            ghash_acc = '0;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_block(input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo,
                              input logic [VB_W-1:0] vb, input logic lst);
        while (src_idle_on && $urandom_range(99) < 31) begin
            blk_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        blk_if.valid       <= 1'b1;
        blk_if.data_hi     <= hi;
        blk_if.data_lo     <= lo;
        blk_if.valid_bytes <= vb;
        blk_if.last        <= lst;
        do begin
            @(posedge i_clk);
        end while (!(blk_if.valid && blk_if.ready));
        ghash_absorb({hi, lo}, vb, lst);
        blocks_sent++;
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every expected tag is out and the pipeline is empty.
    task automatic settle();
        blk_if.valid <= 1'b0;
        while (tag_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_key(input t_u128 key);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_KEY_HI;
        i_cfg_data <= key[127:64];
        @(negedge i_clk);
        i_cfg_idx  <= REG_KEY_LO;
        i_cfg_data <= key[63:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        hash_key = key;
        @(negedge i_clk);
    endtask

    function automatic t_u128 rand_u128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic send_message(input int len, input logic [VB_W-1:0] final_vb);
        t_u128 blk;
        for (int k = 0; k < len; k++) begin
            blk = rand_u128();
            if (k == len - 1) begin
                send_block(blk[127:64], blk[63:0], final_vb, 1'b1);
            end else begin
                send_block(blk[127:64], blk[63:0], VB_W'(NUM_BYTES), 1'b0);
            end
        end
    endtask

    // With the reset key every product is zero, so every tag must be zero.
    task automatic test_reset_state();
        send_block('1, '1, VB_W'(NUM_BYTES), 1'b0);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, VB_W'(NUM_BYTES), 1'b1);
        send_block('0, '0, '0, 1'b1);
    endtask

    task automatic test_directed();
        write_key(128'h66e94bd4ef8a2c3b884cfa59ca342b2e);
        // A message with no data blocks.
        send_block('1, '1, '0, 1'b1);
        send_block('1, '1, VB_W'(16), 1'b1);
        send_block('0, '0, VB_W'(16), 1'b1);
        send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, VB_W'(16), 1'b1);
        // Partial blocks around the half boundary and oversized counts.
        send_block('1, '1, VB_W'(1), 1'b1);
        send_block('1, '1, VB_W'(7), 1'b1);
        send_block('1, '1, VB_W'(8), 1'b1);
        send_block('1, '1, VB_W'(9), 1'b1);
        send_block('1, '1, VB_W'(15), 1'b1);
        send_block('1, '1, VB_W'(17), 1'b1);
        send_block('1, '1, VB_W'(31), 1'b1);
        // A zero count inside a message leaves the accumulator alone.
        send_block('1, '0, VB_W'(16), 1'b0);
        send_block('1, '1, '0, 1'b0);
        send_block(64'h8000000000000000, '0, VB_W'(16), 1'b1);
        // An empty final block emits the accumulator as it stands.
        send_block(64'hdeadbeefcafef00d, 64'h0badc0de12345678, VB_W'(16), 1'b0);
        send_block('1, '1, '0, 1'b1);
    endtask

    task automatic test_key_settings();
        t_u128 keys[4];
        keys[0] = '0;
        keys[1] = '1;
        keys[2] = {1'b1, 127'b0};   // the multiplicative identity
        keys[3] = 128'h1;
        foreach (keys[k]) begin
            write_key(keys[k]);
            send_message(1, VB_W'(16));
            send_message(3, VB_W'($urandom_range(1, 16)));
            send_block('1, '1, VB_W'(16), 1'b1);
        end
    endtask

    // The receiver holds off while blocks keep arriving, so tags back up into the input.
    task automatic test_backpressure();
        t_u128 blk;
        write_key(rand_u128());
        src_idle_on = 0;
        hold_req <= 1'b1;
        for (int k = 0; k < 40; k++) begin
            blk = rand_u128();
            send_block(blk[127:64], blk[63:0], VB_W'($urandom_range(0, 31)), (k % 3) == 2);
        end
        src_idle_on = 1;
        settle();
    endtask

    task automatic test_random();
        int    pick;
        t_u128 blk;
        for (int phase = 0; phase < 5; phase++) begin
            write_key(rand_u128());
            src_idle_on  = (phase != 2);
            sink_idle_on = (phase != 2);
            blocks_sent = 0;
            while (blocks_sent < 300) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    send_message($urandom_range(1, 6), VB_W'($urandom_range(1, 16)));
                end else if (pick < 92) begin
                    blk = rand_u128();
                    send_block(blk[127:64], blk[63:0], VB_W'($urandom_range(0, 31)),
                               1'($urandom_range(0, 1)));
                end else begin
                    send_block({$urandom, $urandom}, {$urandom, $urandom}, '0, 1'b1);
                end
            end
        end
        src_idle_on  = 1;
        sink_idle_on = 1;
    endtask

    // Receiver: random stalls, and a long hold-off when one is requested.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req <= 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                tag_if.ready <= 1'b0;
            end else begin
                tag_if.ready <= !(sink_idle_on && $urandom_range(99) < 31);
            end
        end
    end

    always @(posedge i_clk) begin
        t_u128 want;
        if (i_rst_n && tag_if.valid && tag_if.ready) begin
            if (tag_q.size() == 0) begin
                $display("%0t: unexpected tag transaction: expected none, got %h_%h",
                         $time, tag_if.tag_hi, tag_if.tag_lo);
                errors++;
            end else begin
                want = tag_q.pop_front();
                if (tag_if.tag_hi !== want[127:64]) begin
                    $display("%0t: tag_hi mismatch: expected %h, got %h",
                             $time, want[127:64], tag_if.tag_hi);
                    errors++;
                end
                if (tag_if.tag_lo !== want[63:0]) begin
                    $display("%0t: tag_lo mismatch: expected %h, got %h",
                             $time, want[63:0], tag_if.tag_lo);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((blk_if.valid && blk_if.ready) || (tag_if.valid && tag_if.ready) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("ghash_gf128_accumulator test failed");
            $finish;
        end
    end

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = REG_KEY_HI;
        i_cfg_data         = '0;
        blk_if.valid       = 1'b0;
        blk_if.data_hi     = '0;
        blk_if.data_lo     = '0;
        blk_if.valid_bytes = '0;
        blk_if.last        = 1'b0;
        tag_if.ready       = 1'b0;
        hash_key           = '0;
        ghash_acc          = '0;
        errors             = 0;
        blocks_sent        = 0;
        quiet_cycles       = 0;
        src_idle_on        = 1;
        sink_idle_on       = 1;
        hold_req           = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_directed();
        test_key_settings();
        test_backpressure();
        test_random();

        settle();
        repeat (8) @(posedge i_clk);
        if (tag_q.size() != 0) begin
            $display("%0t: %0d expected tags never arrived", $time, tag_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("ghash_gf128_accumulator test passed");
        end else begin
            $display("ghash_gf128_accumulator test failed");
        end
        $finish;
    end

endmodule
